// ===== rtl/core/pcl_pkg.sv =====
// Shared types and constants for the peak compressor with linear ramps.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package pcl_pkg;

   // Sample and counter widths.
   localparam int SAMPLE_BITS    = 24;
   localparam int COUNT_BITS     = 16;
   localparam int LVL_BITS       = SAMPLE_BITS - 1;
   localparam int FRAC_BITS      = 16;
   localparam int GAIN_BITS      = 16;
   localparam int GAIN_FRAC      = 12;
   localparam int TDATA_BITS     = ((SAMPLE_BITS + 7) / 8) * 8;

   // Shared multiplier and divider sizes.
   localparam int MULB_BITS      = (COUNT_BITS > FRAC_BITS) ? COUNT_BITS : FRAC_BITS;
   localparam int PROD_BITS      = SAMPLE_BITS + MULB_BITS;
   localparam int QUO_BITS       = LVL_BITS + COUNT_BITS;
   localparam int DIV_CNT_BITS   = $clog2(QUO_BITS);
   localparam int Y_BITS         = PROD_BITS - GAIN_FRAC;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   // Register values after reset.
   localparam logic [LVL_BITS-1:0]   THRESHOLD_RESET = LVL_BITS'(4194304);
   localparam logic [FRAC_BITS-1:0]  FRACTION_RESET  = FRAC_BITS'(49152);
   localparam logic [COUNT_BITS-1:0] ATTACK_RESET    = COUNT_BITS'(441);
   localparam logic [COUNT_BITS-1:0] RELEASE_RESET   = COUNT_BITS'(4410);
   localparam logic [GAIN_BITS-1:0]  MAKEUP_RESET    = GAIN_BITS'(4096);

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_THRESHOLD = 3'd0,
      REG_FRACTION  = 3'd1,
      REG_ATTACK    = 3'd2,
      REG_RELEASE   = 3'd3,
      REG_MAKEUP    = 3'd4
   } csr_index_type;

   // Operand selection for the shared multiplier.
   typedef enum logic [1:0] {
      MUL_REDUCTION,
      MUL_ATTACK,
      MUL_RELEASE,
      MUL_MAKEUP
   } mul_sel_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_REDUCE,
      ST_ATTACK_MUL,
      ST_ATTACK_FULL,
      ST_RELEASE_CHECK,
      ST_RELEASE_MUL,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_CUT,
      ST_APPLY,
      ST_MAKEUP,
      ST_FINISH
   } state_type;

   // Current register settings.
   typedef struct packed {
      logic [LVL_BITS-1:0]   threshold;
      logic [FRAC_BITS-1:0]  fraction;
      logic [COUNT_BITS-1:0] attack_len;
      logic [COUNT_BITS-1:0] release_len;
      logic [GAIN_BITS-1:0]  makeup;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_sample;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        held_load;
      logic        cut_clear;
      logic        cut_from_held;
      logic        cut_from_quo;
      logic        atk_step;
      logic        atk_clear;
      logic        rel_load;
      logic        rel_dec;
      logic        divisor_load;
      logic        divisor_rel;
      logic        div_start;
      logic        div_step;
      logic        mag_apply;
      logic        out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic above;
      logic below;
      logic atk_ramp;
      logic rel_active;
      logic rel_nonzero;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/pcl_ctrl.sv =====
// Sequencing state machine of the peak compressor.
// Depends on pcl_pkg; drives the datapath through cmd_type and reads status_type.
`timescale 1ns / 1ps

module pcl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  pcl_pkg::status_type status,
   output pcl_pkg::cmd_type    cmd
);
   import pcl_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (status.above) begin
               state_in = ST_REDUCE;
            end else if (status.below) begin
               state_in = ST_RELEASE_CHECK;
            end else begin
               state_in = ST_APPLY;
            end
         end
         ST_REDUCE: begin
            state_in = status.atk_ramp ? ST_ATTACK_MUL : ST_ATTACK_FULL;
         end
         ST_ATTACK_MUL:  state_in = ST_DIV_LOAD;
         ST_ATTACK_FULL: state_in = ST_APPLY;
         ST_RELEASE_CHECK: begin
            if (status.rel_active && status.rel_nonzero) begin
               state_in = ST_RELEASE_MUL;
            end else begin
               state_in = ST_APPLY;
            end
         end
         ST_RELEASE_MUL: state_in = ST_DIV_LOAD;
         ST_DIV_LOAD:    state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_CUT;
         end
         ST_CUT:    state_in = ST_APPLY;
         ST_APPLY:  state_in = ST_MAKEUP;
         ST_MAKEUP: state_in = ST_FINISH;
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs per state.
   always_comb begin
      cmd        = '0;
      cmd.mul_sel = MUL_REDUCTION;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready      = 1'b1;
            cmd.load_sample = req_tvalid;
         end
         ST_COMPARE: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_REDUCTION;
            cmd.cut_clear = 1'b1;
         end
         ST_REDUCE: begin
            cmd.held_load = 1'b1;
         end
         ST_ATTACK_MUL: begin
            cmd.mul_en       = 1'b1;
            cmd.mul_sel      = MUL_ATTACK;
            cmd.atk_step     = 1'b1;
            cmd.rel_load     = 1'b1;
            cmd.divisor_load = 1'b1;
            cmd.divisor_rel  = 1'b0;
         end
         ST_ATTACK_FULL: begin
            cmd.cut_from_held = 1'b1;
            cmd.rel_load      = 1'b1;
         end
         ST_RELEASE_CHECK: begin
            cmd.atk_clear = 1'b1;
            // With a zero release length the position still counts down.
            cmd.rel_dec   = status.rel_active && !status.rel_nonzero;
         end
         ST_RELEASE_MUL: begin
            cmd.mul_en       = 1'b1;
            cmd.mul_sel      = MUL_RELEASE;
            cmd.rel_dec      = 1'b1;
            cmd.divisor_load = 1'b1;
            cmd.divisor_rel  = 1'b1;
         end
         ST_DIV_LOAD: cmd.div_start    = 1'b1;
         ST_DIVIDE:   cmd.div_step     = 1'b1;
         ST_CUT:      cmd.cut_from_quo = 1'b1;
         ST_APPLY:    cmd.mag_apply    = 1'b1;
         ST_MAKEUP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_MAKEUP;
         end
         ST_FINISH: cmd.out_load = status.out_free;
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/core/pcl_datapath.sv =====
// Datapath of the peak compressor: magnitude, shared multiplier, bit-serial
// divider, ramp state and the output word register. Depends on pcl_pkg.
`timescale 1ns / 1ps

module pcl_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  pcl_pkg::cfg_type                cfg,
   input  pcl_pkg::cmd_type                cmd,
   output pcl_pkg::status_type             status,
   input  logic [pcl_pkg::TDATA_BITS-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pcl_pkg::TDATA_BITS-1:0]  rsp_tdata
);
   import pcl_pkg::*;

   localparam logic [SAMPLE_BITS-1:0] HALF = {1'b1, {LVL_BITS{1'b0}}};
   localparam logic [PROD_BITS-1:0]   ROUND_HALF = PROD_BITS'(1) << (GAIN_FRAC - 1);

   logic                    neg_ff, neg_in;
   logic [SAMPLE_BITS-1:0]  mag_ff, mag_in;
   logic [PROD_BITS-1:0]    prod_ff, prod_in;
   logic [LVL_BITS-1:0]     held_ff, held_in;
   logic [LVL_BITS-1:0]     cut_ff, cut_in;
   logic [COUNT_BITS-1:0]   atk_pos_ff, atk_pos_in;
   logic [COUNT_BITS-1:0]   rel_pos_ff, rel_pos_in;
   logic [COUNT_BITS-1:0]   divisor_ff, divisor_in;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [QUO_BITS-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]  rsp_data_ff, rsp_data_in;

   logic [SAMPLE_BITS-1:0]  sample;
   logic                    sample_neg;
   logic [SAMPLE_BITS-1:0]  sample_mag;
   logic [SAMPLE_BITS-1:0]  thr_ext;
   logic [SAMPLE_BITS-1:0]  mul_a;
   logic [MULB_BITS-1:0]    mul_b;
   logic [COUNT_BITS:0]     rem_shift;
   logic [COUNT_BITS:0]     rem_diff;
   logic [LVL_BITS-1:0]     quo_clamped;
   logic [SAMPLE_BITS-1:0]  cut_ext;
   logic [SAMPLE_BITS-1:0]  reduced;
   logic [PROD_BITS-1:0]    round_sum;
   logic [Y_BITS-1:0]       y_full;
   logic [SAMPLE_BITS-1:0]  y_lim;
   logic [SAMPLE_BITS-1:0]  y_sat;
   logic [SAMPLE_BITS-1:0]  y_signed;

   // Magnitude of the incoming word; the most negative code gives 2^(N-1).
   assign sample     = req_tdata[SAMPLE_BITS-1:0];
   assign sample_neg = sample[SAMPLE_BITS-1];
   assign sample_mag = sample_neg ? (SAMPLE_BITS'(0) - sample) : sample;
   assign thr_ext    = {1'b0, cfg.threshold};

   // Status toward the controller.
   always_comb begin
      status.above       = mag_ff > thr_ext;
      status.below       = mag_ff < thr_ext;
      status.atk_ramp    = atk_pos_ff < cfg.attack_len;
      status.rel_active  = rel_pos_ff != '0;
      status.rel_nonzero = cfg.release_len != '0;
      status.div_last    = div_cnt_ff == DIV_CNT_BITS'(QUO_BITS - 1);
      status.out_free    = !rsp_valid_ff || rsp_tready;
   end

   // Shared multiplier operand selection.
   always_comb begin
      case (cmd.mul_sel)
         MUL_REDUCTION: begin
            mul_a = mag_ff - thr_ext;
            mul_b = MULB_BITS'(cfg.fraction);
         end
         MUL_ATTACK: begin
            mul_a = {1'b0, held_ff};
            mul_b = MULB_BITS'(atk_pos_ff);
         end
         MUL_RELEASE: begin
            mul_a = {1'b0, held_ff};
            mul_b = MULB_BITS'(rel_pos_ff);
         end
         default: begin
            mul_a = mag_ff;
            mul_b = MULB_BITS'(cfg.makeup);
         end
      endcase
   end

   // Restoring division step: one quotient bit per cycle.
   assign rem_shift = {rem_ff, quo_ff[QUO_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};

   // A ramp quotient larger than the held value saturates at it.
   assign quo_clamped = (quo_ff > QUO_BITS'(held_ff)) ? held_ff : quo_ff[LVL_BITS-1:0];

   // Magnitude after reduction, clamped at zero.
   assign cut_ext = {1'b0, cut_ff};
   assign reduced = (cut_ext >= mag_ff) ? '0 : (mag_ff - cut_ext);

   // Makeup rounding, saturation and sign.
   assign round_sum = prod_ff + ROUND_HALF;
   assign y_full    = round_sum[PROD_BITS-1:GAIN_FRAC];
   assign y_lim     = neg_ff ? HALF : (HALF - SAMPLE_BITS'(1));
   assign y_sat     = (y_full > Y_BITS'(y_lim)) ? y_lim : y_full[SAMPLE_BITS-1:0];
   assign y_signed  = neg_ff ? (SAMPLE_BITS'(0) - y_sat) : y_sat;

   // Working registers, next values.
   always_comb begin
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      prod_in    = prod_ff;
      cut_in     = cut_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.load_sample) begin
         neg_in = sample_neg;
         mag_in = sample_mag;
      end else if (cmd.mag_apply) begin
         mag_in = reduced;
      end
      if (cmd.mul_en) begin
         prod_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
      end
      if (cmd.cut_clear) begin
         cut_in = '0;
      end else if (cmd.cut_from_held) begin
         cut_in = held_ff;
      end else if (cmd.cut_from_quo) begin
         cut_in = quo_clamped;
      end
      if (cmd.divisor_load) begin
         divisor_in = cmd.divisor_rel ? cfg.release_len : cfg.attack_len;
      end
      if (cmd.div_start) begin
         rem_in     = '0;
         quo_in     = prod_ff[QUO_BITS-1:0];
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         if (!rem_diff[COUNT_BITS]) begin
            rem_in = rem_diff[COUNT_BITS-1:0];
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[COUNT_BITS-1:0];
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b0};
         end
         div_cnt_in = div_cnt_ff + DIV_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      prod_ff    <= prod_in;
      cut_ff     <= cut_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      div_cnt_ff <= div_cnt_in;
   end

   // Ramp state, next values.
   always_comb begin
      held_in    = held_ff;
      atk_pos_in = atk_pos_ff;
      rel_pos_in = rel_pos_ff;
      if (cmd.held_load) begin
         held_in = prod_ff[FRAC_BITS +: LVL_BITS];
      end
      if (cmd.atk_step) begin
         atk_pos_in = atk_pos_ff + COUNT_BITS'(1);
      end else if (cmd.atk_clear) begin
         atk_pos_in = '0;
      end
      if (cmd.rel_load) begin
         rel_pos_in = cfg.release_len;
      end else if (cmd.rel_dec) begin
         rel_pos_in = rel_pos_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         atk_pos_ff <= '0;
         rel_pos_ff <= '0;
      end else begin
         held_ff    <= held_in;
         atk_pos_ff <= atk_pos_in;
         rel_pos_ff <= rel_pos_in;
      end
   end

   // Output word register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = y_signed;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_BITS'(rsp_data_ff);

   // A loaded magnitude never exceeds half scale.
   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_sample |=> mag_ff <= HALF)
      else $error("sample magnitude out of range");

   // The divider remainder stays below the divisor throughout the division.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < divisor_ff)
      else $error("divider remainder not below divisor");

   // A ramped reduction never exceeds the held reduction.
   a_cut_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.cut_from_quo |=> cut_ff <= held_ff)
      else $error("ramped reduction above held reduction");

   // A result word is loaded only when the output slot is free.
   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result word overwritten");

endmodule

// ===== rtl/core/peak_compressor_linear_ramps.sv =====
// Peak compressor on signed audio words with linear attack and release ramps.
// Holds the configuration registers; instantiates pcl_ctrl and pcl_datapath.
// Depends on pcl_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   req_*  : one signed Q1.23 audio word per transfer (tvalid/tready).
//   rsp_*  : one compressed, makeup-scaled, saturated word per input word.
//   csr_*  : register writes (index, data); always ready. Indexes are
//            0 threshold, 1 reduction fraction, 2 attack length,
//            3 release length, 4 makeup gain; other indexes are ignored.
//            Write only while no word is in flight.
// One word is processed at a time. A word equal to the threshold passes
// compare, apply, makeup and finish; one below it with no release ramp
// running adds a release check, and one above it past the attack ramp adds
// reduce and a full-attack step; a word that ramps also runs the divider,
// one quotient bit per cycle through a 39-bit dividend. The next word is
// accepted when the controller is back in idle, after the result is loaded.
// Reset clears the ramp state and loads the default register values.
// When the receiver stalls, the finished word waits in the output register;
// one more word can be accepted and computed, then the block waits.
//

module peak_compressor_linear_ramps (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: sample_in[23:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pcl_pkg::TDATA_BITS-1:0]      req_tdata,
   // tdata: sample_out[23:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pcl_pkg::TDATA_BITS-1:0]      rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pcl_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import pcl_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // Register file write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_THRESHOLD: cfg_in.threshold   = csr_data[LVL_BITS-1:0];
            REG_FRACTION:  cfg_in.fraction    = csr_data[FRAC_BITS-1:0];
            REG_ATTACK:    cfg_in.attack_len  = csr_data[COUNT_BITS-1:0];
            REG_RELEASE:   cfg_in.release_len = csr_data[COUNT_BITS-1:0];
            REG_MAKEUP:    cfg_in.makeup      = csr_data[GAIN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold   <= THRESHOLD_RESET;
         cfg_ff.fraction    <= FRACTION_RESET;
         cfg_ff.attack_len  <= ATTACK_RESET;
         cfg_ff.release_len <= RELEASE_RESET;
         cfg_ff.makeup      <= MAKEUP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Sequencer.
   pcl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Arithmetic and state.
   pcl_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
